// ===== hw/rtl/tpr_pkg.sv =====
// tpr_pkg: widths, latencies, shared types and elaboration-time tables for the
// accelerometer tilt pipeline (square root and cordic stages)
// no dependencies
package tpr_pkg;

    localparam int IN_W         = 16;
    localparam int MAG_W        = 17;
    localparam int SQ_W         = 31;
    localparam int SUM_W        = 32;
    localparam int FRAC         = 44;
    localparam int SQRT_STEPS   = 60;
    localparam int ROOT_W       = 60;
    localparam int LANE_W       = 61;
    localparam int CORDIC_STEPS = 58;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 3;
    localparam int OCT_W        = 45;
    localparam int BASE_W       = 47;
    localparam int PITCH_W      = 16;
    localparam int ROLL_W       = 15;

    localparam logic [BASE_W-1:0] QUARTER_Q32 = BASE_W'(64'd11520 << 32);
    localparam logic [BASE_W-1:0] HALF_Q32    = BASE_W'(64'd23040 << 32);
    localparam logic [BASE_W:0]   ROUND_HALF  = (BASE_W+1)'(64'd1 << 31);

    typedef logic signed [63:0] atan_tab_t [CORDIC_STEPS];

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [MAG_W-1:0] az;
        logic             x_neg;
        logic             y_neg;
        logic             z_neg;
    } samp_t;

    typedef struct packed {
        logic zero_num;
        logic zero_den;
        logic swap;
        logic den_neg;
        logic num_neg;
    } lane_flags_t;

    typedef struct packed {
        lane_flags_t pitch;
        lane_flags_t roll;
    } angle_flags_t;

    // restoring shift and subtract quotient for the table builders
    function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // arctan(1/5) in q61 by its series
    function automatic logic [63:0] atan_inv5();
        logic [63:0] p;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] k;
        p   = div_u64(64'd1 << 61, 64'd5);
        acc = '0;
        k   = '0;
        while (p != 0) begin
            term = div_u64(p, 2 * k + 64'd1);
            if (k[0]) acc = acc - term;
            else acc = acc + term;
            p = div_u64(p, 64'd25);
            k = k + 64'd1;
        end
        return acc;
    endfunction

    // arctan(1/239) in q61 by its series
    function automatic logic [63:0] atan_inv239();
        logic [63:0] p;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] k;
        p   = div_u64(64'd1 << 61, 64'd239);
        acc = '0;
        k   = '0;
        while (p != 0) begin
            term = div_u64(p, 2 * k + 64'd1);
            if (k[0]) acc = acc - term;
            else acc = acc + term;
            p = div_u64(p, 64'd57121);
            k = k + 64'd1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] quarter_pi_q61();
        return 64'd4 * atan_inv5() - atan_inv239();
    endfunction

    function automatic atan_tab_t build_atan_tab();
        atan_tab_t   tab;
        logic [63:0] acc;
        logic [63:0] term;
        int          k;
        tab[0] = signed'(quarter_pi_q61());
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            acc = '0;
            k   = 0;
            while (i * (2 * k + 1) <= 61) begin
                term = div_u64(64'd1 << (61 - i * (2 * k + 1)), 64'(2 * k + 1));
                if (k[0]) acc = acc - term;
                else acc = acc + term;
                k = k + 1;
            end
            tab[i] = signed'(acc);
        end
        return tab;
    endfunction

    // floor(23040 * 2^50 / pi), low 64 bits of the quotient
    function automatic logic [63:0] units_per_rad_q50();
        logic [63:0] pi_q61;
        logic [63:0] r;
        logic [63:0] q;
        pi_q61 = 64'd4 * quarter_pi_q61();
        r      = 64'd23040;
        q      = '0;
        for (int i = 0; i < 111; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= pi_q61) begin
                r    = r - pi_q61;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    localparam atan_tab_t   ATAN_TAB     = build_atan_tab();
    localparam logic [63:0] UNITS_PER_RAD = units_per_rad_q50();

endpackage

// ===== hw/rtl/tpr_sqrt.sv =====
// tpr_sqrt: bit-per-stage pipelined square root, floor(sqrt(s * 2^88))
// depends on tpr_pkg
module tpr_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [tpr_pkg::SUM_W-1:0]    s,
    output logic [tpr_pkg::ROOT_W-1:0]   root
);

    localparam int STEPS = tpr_pkg::SQRT_STEPS;

    logic [63:0]                  rem_reg  [STEPS];
    logic [63:0]                  root_reg [STEPS];
    logic [tpr_pkg::SUM_W-1:0]    s_reg    [STEPS];

    logic [63:0]                  rem_in   [STEPS];
    logic [63:0]                  root_in  [STEPS];
    logic [tpr_pkg::SUM_W-1:0]    s_in     [STEPS];
    logic [63:0]                  rem_next [STEPS];
    logic [63:0]                  root_next[STEPS];

    always_comb
    begin
        logic [63:0] rem_sh;
        logic [63:0] trial;
        logic [1:0]  two;
        int          p;
        for (int j = 0; j < STEPS; j++) begin
            if (j == 0) begin
                rem_in[j]  = '0;
                root_in[j] = '0;
                s_in[j]    = s;
            end else begin
                rem_in[j]  = rem_reg[j-1];
                root_in[j] = root_reg[j-1];
                s_in[j]    = s_reg[j-1];
            end
            p = STEPS - 1 - j;
            if (p >= tpr_pkg::FRAC)
                two = 2'(s_in[j] >> (2 * (p - tpr_pkg::FRAC)));
            else
                two = 2'b00;
            rem_sh = {rem_in[j][61:0], two};
            trial  = {root_in[j][61:0], 2'b01};
            if (rem_sh >= trial) begin
                rem_next[j]  = rem_sh - trial;
                root_next[j] = {root_in[j][62:0], 1'b1};
            end else begin
                rem_next[j]  = rem_sh;
                root_next[j] = {root_in[j][62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < STEPS; j++) begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                s_reg[j]    <= s_in[j];
            end
        end
    end

    assign root = root_reg[STEPS-1][tpr_pkg::ROOT_W-1:0];

endmodule

// ===== hw/rtl/tpr_cordic.sv =====
// tpr_cordic: pipelined vectoring cordic for atan(a/b), a <= b, in q32 units
// of 1/128 degree; one stage per rotation, then a split 64x64 high product
// depends on tpr_pkg
module tpr_cordic (
    input  logic                        clk,
    input  logic                        en,
    input  logic [tpr_pkg::LANE_W-1:0]  a,
    input  logic [tpr_pkg::LANE_W-1:0]  b,
    output logic [tpr_pkg::OCT_W-1:0]   units
);

    localparam int STEPS = tpr_pkg::CORDIC_STEPS;

    logic signed [63:0] x_reg [STEPS+1];
    logic signed [63:0] y_reg [STEPS+1];
    logic signed [63:0] z_reg [STEPS+1];
    logic signed [63:0] x_next[STEPS];
    logic signed [63:0] y_next[STEPS];
    logic signed [63:0] z_next[STEPS];

    logic [63:0]  z_clamp;
    logic [63:0]  pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [127:0] prod;
    logic [tpr_pkg::OCT_W-1:0] units_reg;

    always_comb
    begin
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        for (int i = 0; i < STEPS; i++) begin
            // shifts truncate toward zero
            dx = y_reg[i][63] ? -((-y_reg[i]) >>> i) : (y_reg[i] >>> i);
            dy = x_reg[i][63] ? -((-x_reg[i]) >>> i) : (x_reg[i] >>> i);
            if (!y_reg[i][63]) begin
                x_next[i] = x_reg[i] + dx;
                y_next[i] = y_reg[i] - dy;
                z_next[i] = z_reg[i] + tpr_pkg::ATAN_TAB[i];
            end else begin
                x_next[i] = x_reg[i] - dx;
                y_next[i] = y_reg[i] + dy;
                z_next[i] = z_reg[i] - tpr_pkg::ATAN_TAB[i];
            end
        end
    end

    assign z_clamp = z_reg[STEPS][63] ? 64'd0 : 64'(z_reg[STEPS]);

    assign prod = {64'd0, pp_ll_reg}
                + ({64'd0, pp_lh_reg} << 32)
                + ({64'd0, pp_hl_reg} << 32)
                + {pp_hh_reg, 64'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= signed'({3'b000, b});
            y_reg[0] <= signed'({3'b000, a});
            z_reg[0] <= '0;
            for (int i = 0; i < STEPS; i++) begin
                x_reg[i+1] <= x_next[i];
                y_reg[i+1] <= y_next[i];
                z_reg[i+1] <= z_next[i];
            end
            pp_ll_reg <= z_clamp[31:0]  * tpr_pkg::UNITS_PER_RAD[31:0];
            pp_lh_reg <= z_clamp[31:0]  * tpr_pkg::UNITS_PER_RAD[63:32];
            pp_hl_reg <= z_clamp[63:32] * tpr_pkg::UNITS_PER_RAD[31:0];
            pp_hh_reg <= z_clamp[63:32] * tpr_pkg::UNITS_PER_RAD[63:32];
            units_reg <= prod[79 +: tpr_pkg::OCT_W];
        end
    end

    assign units = units_reg;

endmodule

// ===== hw/rtl/accel_tilt_pitch_roll_core.sv =====
// accel_tilt_pitch_roll_core: streaming tilt angles from raw accelerometer counts
// depends on tpr_pkg, tpr_sqrt, tpr_cordic
//
// input channel: in_valid / in_stall with accel_x, accel_y, accel_z (signed counts)
// output channel: out_valid / out_stall with pitch_angle and roll_angle in
// units of 1/128 degree, pitch = atan2(-x, z), roll = atan2(y, sqrt(x^2 + z^2))
// a request is taken on a rising edge where valid is high and stall is low
// one request enters per cycle unless stalled; every request gives exactly one result
// 124 register stages: input and squaring stages (2), the 60-stage square root,
// the 58-stage cordic with its input and product stages (61), and the output
// register; out_valid rises once the request reaches the output register
// throughput is one request per cycle unless the receiver stalls, set by the fully
// pipelined square root and cordic, each stage holding one digit or one rotation
// reset clears all valid bits and the output valid; data registers are not reset
// while the receiver stalls a held result, the whole pipeline freezes and
// in_stall is raised, so nothing is lost or repeated
module accel_tilt_pitch_roll_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [tpr_pkg::IN_W-1:0]       accel_x,
    input  logic signed [tpr_pkg::IN_W-1:0]       accel_y,
    input  logic signed [tpr_pkg::IN_W-1:0]       accel_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [tpr_pkg::PITCH_W-1:0]    pitch_angle,
    output logic signed [tpr_pkg::ROLL_W-1:0]     roll_angle
);

    localparam int SQ_LAT = tpr_pkg::SQRT_STEPS;
    localparam int CD_LAT = tpr_pkg::CORDIC_LAT;
    localparam int N      = 2 + SQ_LAT + CD_LAT;

    logic en;
    logic vld_reg [N];
    logic out_valid_reg;

    logic signed [tpr_pkg::IN_W-1:0] x_reg, y_reg, z_reg;
    tpr_pkg::samp_t                  samp_next;
    tpr_pkg::samp_t                  samp1_reg;
    logic [tpr_pkg::SQ_W-1:0]        sqx_reg, sqz_reg;
    logic [tpr_pkg::SUM_W-1:0]       sum_sq;
    tpr_pkg::samp_t                  samp_dly_reg [SQ_LAT];
    logic [tpr_pkg::ROOT_W-1:0]      root;

    tpr_pkg::samp_t                  sd;
    logic [tpr_pkg::LANE_W-1:0]      num_p, den_p, num_r, den_r;
    logic [tpr_pkg::LANE_W-1:0]      a_p, b_p, a_r, b_r;
    tpr_pkg::angle_flags_t           flg_next;
    tpr_pkg::angle_flags_t           flg_reg [CD_LAT];
    logic [tpr_pkg::OCT_W-1:0]       units_p, units_r;

    logic signed [tpr_pkg::PITCH_W-1:0] pitch_next, pitch_reg;
    logic signed [tpr_pkg::PITCH_W-1:0] roll_full;
    logic signed [tpr_pkg::ROLL_W-1:0]  roll_reg;

    function automatic logic signed [tpr_pkg::PITCH_W-1:0] finish_angle(
        input tpr_pkg::lane_flags_t        f,
        input logic [tpr_pkg::OCT_W-1:0]   oct
    );
        logic [tpr_pkg::BASE_W-1:0] base;
        logic [tpr_pkg::BASE_W:0]   rounded;
        logic [tpr_pkg::PITCH_W-1:0] mag;
        if (f.zero_num)
            base = '0;
        else if (f.zero_den)
            base = tpr_pkg::QUARTER_Q32;
        else if (!f.swap)
            base = tpr_pkg::BASE_W'(oct);
        else
            base = tpr_pkg::QUARTER_Q32 - tpr_pkg::BASE_W'(oct);
        if (f.den_neg)
            base = tpr_pkg::HALF_Q32 - base;
        rounded = {1'b0, base} + tpr_pkg::ROUND_HALF;
        mag     = rounded[32 +: tpr_pkg::PITCH_W];
        return f.num_neg ? -signed'(mag) : signed'(mag);
    endfunction

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // magnitudes and signs, -32768 taken at full size
    always_comb
    begin
        samp_next.x_neg = x_reg[tpr_pkg::IN_W-1];
        samp_next.y_neg = y_reg[tpr_pkg::IN_W-1];
        samp_next.z_neg = z_reg[tpr_pkg::IN_W-1];
        samp_next.ax = x_reg[tpr_pkg::IN_W-1] ? tpr_pkg::MAG_W'(-{x_reg[tpr_pkg::IN_W-1], x_reg})
                                              : {1'b0, x_reg};
        samp_next.ay = y_reg[tpr_pkg::IN_W-1] ? tpr_pkg::MAG_W'(-{y_reg[tpr_pkg::IN_W-1], y_reg})
                                              : {1'b0, y_reg};
        samp_next.az = z_reg[tpr_pkg::IN_W-1] ? tpr_pkg::MAG_W'(-{z_reg[tpr_pkg::IN_W-1], z_reg})
                                              : {1'b0, z_reg};
    end

    assign sum_sq = tpr_pkg::SUM_W'(sqx_reg) + tpr_pkg::SUM_W'(sqz_reg);

    tpr_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .s    (sum_sq),
        .root (root)
    );

    // octant folding for both lanes
    always_comb
    begin
        sd    = samp_dly_reg[SQ_LAT-1];
        num_p = {sd.ax, {tpr_pkg::FRAC{1'b0}}};
        den_p = {sd.az, {tpr_pkg::FRAC{1'b0}}};
        num_r = {sd.ay, {tpr_pkg::FRAC{1'b0}}};
        den_r = {1'b0, root};

        flg_next.pitch.zero_num = (sd.ax == '0);
        flg_next.pitch.zero_den = (sd.az == '0);
        flg_next.pitch.swap     = (num_p > den_p);
        flg_next.pitch.den_neg  = sd.z_neg;
        flg_next.pitch.num_neg  = !sd.x_neg;

        flg_next.roll.zero_num  = (sd.ay == '0);
        flg_next.roll.zero_den  = (root == '0);
        flg_next.roll.swap      = (num_r > den_r);
        flg_next.roll.den_neg   = 1'b0;
        flg_next.roll.num_neg   = sd.y_neg;

        a_p = flg_next.pitch.swap ? den_p : num_p;
        b_p = flg_next.pitch.swap ? num_p : den_p;
        a_r = flg_next.roll.swap  ? den_r : num_r;
        b_r = flg_next.roll.swap  ? num_r : den_r;
    end

    tpr_cordic u_cordic_pitch (
        .clk   (clk),
        .en    (en),
        .a     (a_p),
        .b     (b_p),
        .units (units_p)
    );

    tpr_cordic u_cordic_roll (
        .clk   (clk),
        .en    (en),
        .a     (a_r),
        .b     (b_r),
        .units (units_r)
    );

    assign pitch_next = finish_angle(flg_reg[CD_LAT-1].pitch, units_p);
    assign roll_full  = finish_angle(flg_reg[CD_LAT-1].roll, units_r);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
                vld_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < N; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_valid_reg <= vld_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= accel_x;
            y_reg     <= accel_y;
            z_reg     <= accel_z;
            samp1_reg <= samp_next;
            sqx_reg   <= tpr_pkg::SQ_W'(samp_next.ax) * tpr_pkg::SQ_W'(samp_next.ax);
            sqz_reg   <= tpr_pkg::SQ_W'(samp_next.az) * tpr_pkg::SQ_W'(samp_next.az);
            samp_dly_reg[0] <= samp1_reg;
            for (int k = 1; k < SQ_LAT; k++)
                samp_dly_reg[k] <= samp_dly_reg[k-1];
            flg_reg[0] <= flg_next;
            for (int k = 1; k < CD_LAT; k++)
                flg_reg[k] <= flg_reg[k-1];
            pitch_reg <= pitch_next;
            roll_reg  <= roll_full[tpr_pkg::ROLL_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_reg;

    // a moving pipeline shows the tail valid bit on the next edge
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> out_valid == $past(vld_reg[N-1]))
        else $error("output valid lost or invented");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_reg[N-1]) && $stable(pitch_angle) && $stable(roll_angle))
        else $error("pipeline moved during stall");

    a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_angle >= -16'sd23040) && (pitch_angle <= 16'sd23040))
        else $error("pitch out of range");

    a_roll_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_angle >= -15'sd11520) && (roll_angle <= 15'sd11520))
        else $error("roll out of range");

endmodule
